[design/bbc_pkg.sv]
// shared constants and types for the lru block buffer cache tag manager
package bbc_pkg;

  localparam int ENTRIES = 32;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int LEAVES  = 1 << IDX_W;
  localparam int WAIT_W  = $clog2(IDX_W + 1);

  localparam int CMD_W   = 2;
  localparam int DEV_W   = 8;
  localparam int BLK_W   = 32;
  localparam int EIDX_W  = 5;
  localparam int TIME_W  = 32;
  localparam int CNT_W   = 8;
  localparam int STAT_W  = 2;

  localparam logic [CMD_W-1:0] CMD_READ    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PIN     = 2'd2;
  localparam logic [CMD_W-1:0] CMD_UNPIN   = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOFREE = 2'd1;
  localparam logic [STAT_W-1:0] ST_COUNT  = 2'd2;

  localparam logic [CNT_W-1:0] COUNT_MAX = 8'hFF;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [DEV_W-1:0]  device;
    logic [BLK_W-1:0]  block_number;
    logic [EIDX_W-1:0] entry_index;
    logic [TIME_W-1:0] now;
  } req_t;

  typedef struct packed {
    logic [EIDX_W-1:0] slot;
    logic              hit;
    logic              needs_read;
    logic [STAT_W-1:0] status;
  } rsp_t;

  typedef struct packed {
    logic              vld;
    logic [TIME_W-1:0] tim;
    logic [IDX_W-1:0]  idx;
  } node_t;

  typedef struct packed {
    logic load;
    logic exec;
  } ctrl_cmd_t;

endpackage

[design/bbc_if.sv]
// request and response channel interfaces

interface bbc_req_if;
  logic                             valid;
  logic                             ready;
  logic [bbc_pkg::CMD_W-1:0]        command;
  logic [bbc_pkg::DEV_W-1:0]        device;
  logic [bbc_pkg::BLK_W-1:0]        block_number;
  logic [bbc_pkg::EIDX_W-1:0]       entry_index;
  logic [bbc_pkg::TIME_W-1:0]       now;

  modport source (output valid, command, device, block_number, entry_index, now,
                  input ready);
  modport sink   (input valid, command, device, block_number, entry_index, now,
                  output ready);
endinterface

interface bbc_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [bbc_pkg::EIDX_W-1:0]       slot;
  logic                             hit;
  logic                             needs_read;
  logic [bbc_pkg::STAT_W-1:0]       status;

  modport source (output valid, slot, hit, needs_read, status, input ready);
  modport sink   (input valid, slot, hit, needs_read, status, output ready);
endinterface

[design/bbc_ctrl.sv]
// controller: accepts a transaction, waits for the tag and victim search, then executes
module bbc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               out_ready_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  output bbc_pkg::ctrl_cmd_t cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WAIT = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;

  logic [1:0]                  state_q, state_d;
  logic [bbc_pkg::WAIT_W-1:0]  wait_q, wait_d;
  logic                        out_valid_q, out_valid_d;
  logic                        accept;
  logic                        fire;

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign fire        = (state_q == S_EXEC) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign cmd_o.load  = accept;
  assign cmd_o.exec  = fire;

  always_comb begin
    state_d     = state_q;
    wait_d      = wait_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_WAIT;
          wait_d  = '0;
        end
      end
      S_WAIT: begin
        wait_d = wait_q + 1'b1;
        if (wait_q == bbc_pkg::WAIT_W'(bbc_pkg::IDX_W - 1)) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (fire) begin
          state_d     = S_IDLE;
          out_valid_d = 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wait_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wait_q      <= wait_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

[design/bbc_datapath.sv]
// datapath: entry state, tag compare, registered oldest-free tree, update and result register
module bbc_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bbc_pkg::ctrl_cmd_t cmd_i,
  input  bbc_pkg::req_t      req_i,
  output bbc_pkg::rsp_t      rsp_o
);

  localparam int ENTRIES = bbc_pkg::ENTRIES;
  localparam int IDX_W   = bbc_pkg::IDX_W;
  localparam int LEAVES  = bbc_pkg::LEAVES;

  bbc_pkg::req_t                  req_q;
  bbc_pkg::rsp_t                  rsp_q, rsp_d;

  logic [bbc_pkg::DEV_W-1:0]      tag_dev_q  [ENTRIES];
  logic [bbc_pkg::BLK_W-1:0]      tag_blk_q  [ENTRIES];
  logic [bbc_pkg::CNT_W-1:0]      cnt_q      [ENTRIES];
  logic [bbc_pkg::TIME_W-1:0]     time_q     [ENTRIES];
  logic [ENTRIES-1:0]             dvld_q;
  logic [ENTRIES-1:0]             asg_q;
  logic [ENTRIES-1:0]             match_q;

  bbc_pkg::node_t                 node_q [1:LEAVES-1];
  bbc_pkg::node_t                 node_d [1:LEAVES-1];
  bbc_pkg::node_t                 all_n  [1:2*LEAVES-1];

  logic                           hit_any;
  logic [IDX_W-1:0]               hit_idx;
  logic [IDX_W-1:0]               tgt;
  logic                           in_rng;
  logic [bbc_pkg::CNT_W-1:0]      cnt_cur;
  logic [bbc_pkg::CNT_W-1:0]      cnt_new;
  logic                           wr_cnt;
  logic                           wr_tag;
  logic                           wr_time;

  function automatic bbc_pkg::node_t pick(input bbc_pkg::node_t a, input bbc_pkg::node_t b);
    if (a.vld && (!b.vld || a.tim <= b.tim)) begin
      return a;
    end
    return b;
  endfunction

  // request register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_i;
    end
  end

  // parallel tag compare
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < ENTRIES; i++) begin
      match_q[i] <= asg_q[i] && (tag_dev_q[i] == req_q.device) &&
                    (tag_blk_q[i] == req_q.block_number);
    end
  end

  always_comb begin
    hit_any = |match_q;
    hit_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (match_q[i]) begin
        hit_idx = IDX_W'(i);
      end
    end
  end

  // oldest free entry, one tree level per cycle
  always_comb begin
    for (int n = 1; n < LEAVES; n++) begin
      all_n[n] = node_q[n];
    end
    for (int l = 0; l < LEAVES; l++) begin
      all_n[LEAVES + l].vld = 1'b0;
      all_n[LEAVES + l].tim = '0;
      all_n[LEAVES + l].idx = IDX_W'(l);
    end
    for (int l = 0; l < ENTRIES; l++) begin
      all_n[LEAVES + l].vld = (cnt_q[l] == '0);
      all_n[LEAVES + l].tim = time_q[l];
    end
    for (int n = 1; n < LEAVES; n++) begin
      node_d[n] = pick(all_n[2*n], all_n[2*n + 1]);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int n = 1; n < LEAVES; n++) begin
      node_q[n] <= node_d[n];
    end
  end

  // update and result
  always_comb begin
    in_rng  = (32'(req_q.entry_index) < 32'(ENTRIES));
    if (req_q.command == bbc_pkg::CMD_READ) begin
      tgt = hit_any ? hit_idx : node_q[1].idx;
    end else begin
      tgt = IDX_W'(req_q.entry_index);
    end
    cnt_cur = cnt_q[tgt];
    cnt_new = cnt_cur;
    wr_cnt  = 1'b0;
    wr_tag  = 1'b0;
    wr_time = 1'b0;
    rsp_d.slot       = req_q.entry_index;
    rsp_d.hit        = 1'b0;
    rsp_d.needs_read = 1'b0;
    rsp_d.status     = bbc_pkg::ST_OK;
    case (req_q.command)
      bbc_pkg::CMD_READ: begin
        if (hit_any) begin
          rsp_d.slot = bbc_pkg::EIDX_W'(tgt);
          rsp_d.hit  = 1'b1;
          if (cnt_cur == bbc_pkg::COUNT_MAX) begin
            rsp_d.status = bbc_pkg::ST_COUNT;
          end else begin
            cnt_new          = cnt_cur + 1'b1;
            wr_cnt           = 1'b1;
            rsp_d.needs_read = !dvld_q[tgt];
          end
        end else if (!node_q[1].vld) begin
          rsp_d.slot   = '0;
          rsp_d.status = bbc_pkg::ST_NOFREE;
        end else begin
          rsp_d.slot       = bbc_pkg::EIDX_W'(tgt);
          rsp_d.needs_read = 1'b1;
          cnt_new          = bbc_pkg::CNT_W'(1);
          wr_cnt           = 1'b1;
          wr_tag           = 1'b1;
        end
      end
      bbc_pkg::CMD_PIN: begin
        if (in_rng) begin
          if (cnt_cur == bbc_pkg::COUNT_MAX) begin
            rsp_d.status = bbc_pkg::ST_COUNT;
          end else begin
            cnt_new = cnt_cur + 1'b1;
            wr_cnt  = 1'b1;
          end
        end
      end
      bbc_pkg::CMD_RELEASE, bbc_pkg::CMD_UNPIN: begin
        if (in_rng) begin
          if (cnt_cur == '0) begin
            rsp_d.status = bbc_pkg::ST_COUNT;
          end else begin
            cnt_new = cnt_cur - 1'b1;
            wr_cnt  = 1'b1;
            wr_time = (req_q.command == bbc_pkg::CMD_RELEASE) &&
                      (cnt_cur == bbc_pkg::CNT_W'(1));
          end
        end
      end
      default: begin
        rsp_d.status = bbc_pkg::ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ENTRIES; i++) begin
        cnt_q[i]  <= '0;
        time_q[i] <= '0;
      end
      dvld_q <= '0;
      asg_q  <= '0;
    end else if (cmd_i.exec) begin
      if (wr_cnt) begin
        cnt_q[tgt]  <= cnt_new;
        dvld_q[tgt] <= 1'b1;
      end
      if (wr_tag) begin
        asg_q[tgt] <= 1'b1;
      end
      if (wr_time) begin
        time_q[tgt] <= req_q.now;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && wr_tag) begin
      tag_dev_q[tgt] <= req_q.device;
      tag_blk_q[tgt] <= req_q.block_number;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o = rsp_q;

endmodule

[design/block_buffer_cache_lru_top.sv]
// top level of the lru block buffer cache tag manager
//
//  channel  dir  handshake      payload
//  req_i    in   valid/ready    command, device, block_number, entry_index, now
//  rsp_o    out  valid/ready    slot, hit, needs_read, status
//
// one transaction at a time: the wait before execute is set by the depth
// of the registered oldest-free tree, which settles one level per cycle
// the result register frees req_i.ready while a response waits to be taken
// a stalled response holds back the next execute step and stays unchanged in the result register
// reset clears all counts, release times, valid and assigned bits at once
module block_buffer_cache_lru_top (
  input logic       clk_i,
  input logic       rst_ni,
  bbc_req_if.sink   req_i,
  bbc_rsp_if.source rsp_o
);

  bbc_pkg::ctrl_cmd_t cmd;
  bbc_pkg::req_t      req;
  bbc_pkg::rsp_t      rsp;

  assign req.command      = req_i.command;
  assign req.device       = req_i.device;
  assign req.block_number = req_i.block_number;
  assign req.entry_index  = req_i.entry_index;
  assign req.now          = req_i.now;

  bbc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .out_ready_i (rsp_o.ready),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .cmd_o       (cmd)
  );

  bbc_datapath u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  assign rsp_o.slot       = rsp.slot;
  assign rsp_o.hit        = rsp.hit;
  assign rsp_o.needs_read = rsp.needs_read;
  assign rsp_o.status     = rsp.status;

endmodule

[design/bbc_checker.sv]
// port-level checker for the lru block buffer cache tag manager, with its bind
module bbc_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         req_valid_i,
  input logic                         req_ready_i,
  input logic                         rsp_valid_i,
  input logic                         rsp_ready_i,
  input logic [bbc_pkg::EIDX_W-1:0]   slot_i,
  input logic                         hit_i,
  input logic                         needs_read_i,
  input logic [bbc_pkg::STAT_W-1:0]   status_i
);

  logic req_acc;
  assign req_acc = req_valid_i && req_ready_i;

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(slot_i) && $stable(hit_i) &&
    $stable(needs_read_i) && $stable(status_i))
    else $error("response changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc |=> !req_ready_i)
    else $error("request taken while another is in progress");

  a_hit_no_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && hit_i |-> !needs_read_i && status_i != bbc_pkg::ST_NOFREE)
    else $error("hit reported a disk fill or no free entry");

  a_nofree_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && status_i == bbc_pkg::ST_NOFREE |-> slot_i == '0 && !hit_i && !needs_read_i)
    else $error("no free entry response carries entry data");

  a_fill_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && needs_read_i |-> status_i == bbc_pkg::ST_OK)
    else $error("fill reported with an error status");

endmodule

bind block_buffer_cache_lru_top bbc_checker u_bbc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .slot_i       (rsp_o.slot),
  .hit_i        (rsp_o.hit),
  .needs_read_i (rsp_o.needs_read),
  .status_i     (rsp_o.status)
);
